[src/assert_macros.svh]
// Assertion macros used by the RTL file of the button click classifier.
// Each macro checks a property on the rising edge of clk and stays quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication with overlap (antecedent and consequent in the same cycle).
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/bcc_pkg.sv]
// Package for the button click classifier: mode and event codes,
// configuration register indexes and widths. No dependencies.
package bcc_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_DEBOUNCE = 2'd1,
    MODE_PRESSED  = 2'd2,
    MODE_LONG     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS = 2'd0,
    REG_LONG_PRESS     = 2'd1,
    REG_DOUBLE_CLICK   = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_index_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd300;

endpackage

[src/button_click_classifier_core.sv]
// Top level of the button click classifier: debounce, long press and double click.
// Depends on bcc_pkg for codes and widths, and on assert_macros.svh for checks.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid / in_stall  raw_pressed
//   out      source     out_valid/out_stall  event_res, is_pressed
//   cfg      sink       cfg_we               cfg_index, cfg_data
//
// For every item (one timer tick), the state registers and the result register are
// both updated at the edge that accepts the item, so a new item can be accepted
// every cycle while in_stall is low, and its result is valid on the next cycle.
// The single result register sets the rate; in_stall is high only while that
// register holds an item and the consumer stalls it.
// Reset (rst, synchronous) returns the mode to idle, clears all counters and
// the pending clicks, and loads the register defaults 20, 1000 and 300.
`include "assert_macros.svh"

module button_click_classifier_core
  import bcc_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input channel: one raw button level per item.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 raw_pressed,
  // Output channel: one classified event per item.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           event_res,
  output logic                 is_pressed,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Comparisons run at the wider of the counter and register widths.
  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  // Configuration registers.
  logic [CFG_W-1:0] debounce_ticks;
  logic [CFG_W-1:0] long_press_ticks;
  logic [CFG_W-1:0] double_click_ticks;

  // Classifier state.
  mode_t                 mode, mode_next;
  logic                  for_press, for_press_next;
  logic [TIMER_BITS-1:0] debounce_count, debounce_count_next;
  logic [TIMER_BITS-1:0] hold_count, hold_count_next;
  logic [TIMER_BITS-1:0] since_release, since_release_next;
  logic [1:0]            clicks, clicks_next;
  event_t                ev;

  logic in_accept;
  logic out_accept;

  // Counters saturate at full scale.
  logic [TIMER_BITS-1:0] hold_inc, since_inc, debounce_inc;
  logic [1:0]            clicks_inc;
  logic                  debounce_done;
  logic                  hold_long;
  logic                  gap_over;

  // Conditions watched by the checks at the end of the module.
  logic                  event_held;
  logic                  entering_pressed;

  // The input is stalled only while the result register is full and stalled.
  assign in_stall   = out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  assign hold_inc     = (hold_count == '1) ? hold_count : hold_count + TIMER_BITS'(1);
  assign since_inc    = (since_release == '1) ? since_release
                                              : since_release + TIMER_BITS'(1);
  assign debounce_inc = (debounce_count == '1) ? debounce_count
                                               : debounce_count + TIMER_BITS'(1);
  assign clicks_inc   = clicks + 2'd1;

  // Threshold tests on the advanced counter values of this tick.
  assign debounce_done = CMP_W'(debounce_inc) >= CMP_W'(debounce_ticks);
  assign hold_long     = CMP_W'(hold_inc) >= CMP_W'(long_press_ticks);
  assign gap_over      = CMP_W'(since_inc) > CMP_W'(double_click_ticks);

  // Next mode and the direction of the current debounce.
  always_comb begin
    mode_next      = mode;
    for_press_next = for_press;
    unique case (mode)
      MODE_IDLE: begin
        if (raw_pressed) begin
          mode_next      = MODE_DEBOUNCE;
          for_press_next = 1'b1;
        end
      end
      MODE_DEBOUNCE: begin
        if (debounce_done) begin
          mode_next = raw_pressed ? MODE_PRESSED : MODE_IDLE;
        end
      end
      MODE_PRESSED: begin
        if (!raw_pressed) begin
          mode_next      = MODE_DEBOUNCE;
          for_press_next = 1'b0;
        end else if (hold_long) begin
          mode_next = MODE_LONG;
        end
      end
      MODE_LONG: begin
        if (!raw_pressed) begin
          mode_next      = MODE_DEBOUNCE;
          for_press_next = 1'b0;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  // Counters, click tally and the event of this tick.
  always_comb begin
    debounce_count_next = debounce_count;
    hold_count_next     = hold_inc;
    since_release_next  = since_inc;
    clicks_next         = clicks;
    ev                  = EV_NONE;
    unique case (mode)
      MODE_IDLE: begin
        // A lone click turns into a short press once the gap is long enough.
        if ((clicks != 2'd0) && gap_over) begin
          if (clicks == 2'd1) begin
            ev = EV_SHORT;
          end
          clicks_next = 2'd0;
        end
        if (raw_pressed) begin
          debounce_count_next = '0;
        end
      end
      MODE_DEBOUNCE: begin
        debounce_count_next = debounce_inc;
        if (debounce_done) begin
          if (raw_pressed) begin
            hold_count_next = '0;
          end else if (!for_press) begin
            // A confirmed release: classify the hold that just ended.
            since_release_next = '0;
            if (hold_long) begin
              ev          = EV_LONG;
              clicks_next = 2'd0;
            end else if (clicks_inc >= 2'd2) begin
              ev          = EV_DOUBLE;
              clicks_next = 2'd0;
            end else begin
              clicks_next = clicks_inc;
            end
          end
        end
      end
      MODE_PRESSED, MODE_LONG: begin
        if (!raw_pressed) begin
          debounce_count_next = '0;
        end
      end
      default: begin
        clicks_next = clicks;
      end
    endcase
  end

  // Configuration registers; the unused index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= DEBOUNCE_RESET;
      long_press_ticks   <= LONG_PRESS_RESET;
      double_click_ticks <= DOUBLE_CLICK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_DEBOUNCE_TICKS: debounce_ticks     <= cfg_data;
        REG_LONG_PRESS:     long_press_ticks   <= cfg_data;
        REG_DOUBLE_CLICK:   double_click_ticks <= cfg_data;
        default: begin
          debounce_ticks <= debounce_ticks;
        end
      endcase
    end
  end

  // State registers advance once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      for_press      <= 1'b0;
      debounce_count <= '0;
      hold_count     <= '0;
      since_release  <= '0;
      clicks         <= 2'd0;
    end else if (in_accept) begin
      mode           <= mode_next;
      for_press      <= for_press_next;
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      since_release  <= since_release_next;
      clicks         <= clicks_next;
    end
  end

  // Result register: filled on accept, emptied when the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      event_res  <= ev;
      is_pressed <= (mode_next == MODE_PRESSED) || (mode_next == MODE_LONG);
    end
  end

  assign event_held       = out_valid && (event_res != EV_NONE);
  assign entering_pressed = in_accept && (mode == MODE_DEBOUNCE) && (mode_next == MODE_PRESSED);

  // An event is only ever reported on a tick that leaves the button released.
  `ASSERT_IMPL(a_event_released, event_held, !is_pressed, "event while pressed")
  // At most one click is ever left pending.
  `ASSERT_CLK(a_clicks_bound, clicks <= 2'd1, "more than one pending click")
  // Entering the pressed mode restarts the hold counter.
  `ASSERT_NEXT(a_hold_restart, entering_pressed, hold_count == '0, "hold not restarted")
  // An accepted item always leaves a result waiting.
  `ASSERT_NEXT(a_result_follows, in_accept, out_valid, "result missing after accept")

endmodule

[tb/button_click_classifier_core_tb.sv]
// Testbench for button_click_classifier_core: drives one raw level per item and
// checks every classified event and pressed flag against a cycle-free predictor.
// Depends on bcc_pkg for the event, mode and register codes and the widths.
module button_click_classifier_core_tb;
  import bcc_pkg::*;

  localparam int TIMER_W     = 16;
  // Longest stretch without any accepted item, result or register write.
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    event_t ev;
    logic   pressed;
  } tick_result_t;

  // Clock, reset and every block input start at known values.
  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 raw_pressed = 1'b0;
  logic                 out_stall   = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_DEBOUNCE_TICKS;
  logic [CFG_W-1:0]     cfg_data    = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [1:0]           event_res;
  logic                 is_pressed;

  button_click_classifier_core #(
    .TIMER_BITS(TIMER_W)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_pressed(raw_pressed),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .is_pressed (is_pressed),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state: the classifier's own registers and configuration,
  // advanced once for every item the block accepts.
  logic [TIMER_W-1:0] c_debounce;
  logic [TIMER_W-1:0] c_long;
  logic [TIMER_W-1:0] c_double;
  mode_t              m_mode;
  logic [TIMER_W-1:0] m_debounce_cnt;
  logic [TIMER_W-1:0] m_hold;
  logic [TIMER_W-1:0] m_since;
  logic [1:0]         m_clicks;
  logic               m_from_idle;

  // Events the block still owes, oldest first.
  tick_result_t pending_events[$];

  // Idling controls shared by the input driver and the output stall process.
  bit idle_on   = 1'b0;
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;

  int errors   = 0;
  int n_items  = 0;
  int n_writes = 0;
  int n_short  = 0;
  int n_long   = 0;
  int n_double = 0;
  int quiet    = 0;

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    return (v == {TIMER_W{1'b1}}) ? v : v + TIMER_W'(1);
  endfunction

  task automatic reset_classifier_model();
    c_debounce     = DEBOUNCE_RESET;
    c_long         = LONG_PRESS_RESET;
    c_double       = DOUBLE_CLICK_RESET;
    m_mode         = MODE_IDLE;
    m_debounce_cnt = '0;
    m_hold         = '0;
    m_since        = '0;
    m_clicks       = '0;
    m_from_idle    = 1'b0;
  endtask

  // One timer tick of the classifier: both timers advance first, then the
  // current mode acts on the raw level.
  function automatic tick_result_t classify_tick(input logic raw);
    tick_result_t r;
    event_t       ev;
    ev      = EV_NONE;
    m_hold  = sat_inc(m_hold);
    m_since = sat_inc(m_since);
    case (m_mode)
      MODE_IDLE: begin
        // A lone click turns into a short press once the window has passed.
        if (m_clicks != 2'd0 && m_since > c_double) begin
          if (m_clicks == 2'd1) ev = EV_SHORT;
          m_clicks = 2'd0;
        end
        if (raw) begin
          m_mode         = MODE_DEBOUNCE;
          m_debounce_cnt = '0;
          m_from_idle    = 1'b1;
        end
      end
      MODE_DEBOUNCE: begin
        m_debounce_cnt = sat_inc(m_debounce_cnt);
        // Only the level on the completing tick matters.
        if (m_debounce_cnt >= c_debounce) begin
          if (raw) begin
            m_mode = MODE_PRESSED;
            m_hold = '0;
          end else begin
            m_mode = MODE_IDLE;
            // A press that bounced back leaves the clicks alone.
            if (!m_from_idle) begin
              m_since = '0;
              if (m_hold >= c_long) begin
                ev       = EV_LONG;
                m_clicks = 2'd0;
              end else begin
                m_clicks = m_clicks + 2'd1;
                if (m_clicks >= 2'd2) begin
                  ev       = EV_DOUBLE;
                  m_clicks = 2'd0;
                end
              end
            end
          end
        end
      end
      MODE_PRESSED: begin
        if (m_hold >= c_long) m_mode = MODE_LONG;
        if (!raw) begin
          m_mode         = MODE_DEBOUNCE;
          m_debounce_cnt = '0;
          m_from_idle    = 1'b0;
        end
      end
      default: begin
        if (!raw) begin
          m_mode         = MODE_DEBOUNCE;
          m_debounce_cnt = '0;
          m_from_idle    = 1'b0;
        end
      end
    endcase
    r.ev      = ev;
    r.pressed = (m_mode == MODE_PRESSED || m_mode == MODE_LONG);
    return r;
  endfunction

  // Sends one item. in_valid stays high on return, so a following call in the
  // same time step keeps the stream back to back; settle_block lowers it.
  task automatic send_tick(input logic raw);
    if (idle_on && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    raw_pressed <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_events.push_back(classify_tick(raw));
    n_items++;
  endtask

  task automatic send_level(input logic raw, input int count);
    repeat (count) send_tick(raw);
  endtask

  // Stops the stream and waits until every owed result has come out. Every
  // item yields a result, so an empty queue means the block is idle.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE_TICKS: c_debounce = val;
      REG_LONG_PRESS:     c_long     = val;
      REG_DOUBLE_CLICK:   c_double   = val;
      default: ;
    endcase
    n_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                              input logic [CFG_W-1:0] dbl);
    settle_block();
    write_reg(REG_DEBOUNCE_TICKS, deb);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_DOUBLE_CLICK, dbl);
  endtask

  // A press with optional contact bounce on both edges, then a release gap.
  task automatic press_gesture(input int hold_len, input int rel_len, input int bounce);
    repeat (bounce) send_tick(1'($urandom_range(1)));
    send_level(1'b1, hold_len);
    repeat (bounce) send_tick(1'($urandom_range(1)));
    send_level(1'b0, rel_len);
  endtask

  // Out-of-reset behavior with the default timing: one short press.
  task automatic test_defaults_after_reset();
    idle_on   = 1'b1;
    gap_pct   = 10;
    stall_pct = 10;
    send_level(1'b1, 40);
    send_level(1'b0, 30);
    send_level(1'b0, 300);
    settle_block();
  endtask

  // Directed gestures with tiny windows: single, long and double clicks, a
  // press that bounces away, zero timing values and the unused register slot.
  task automatic test_directed_cases();
    apply_timing(16'd1, 16'd3, 16'd2);
    send_level(1'b1, 2);
    send_level(1'b0, 5);
    send_level(1'b1, 6);
    send_level(1'b0, 2);
    press_gesture(2, 2, 0);
    press_gesture(2, 2, 0);
    send_tick(1'b1);
    send_tick(1'b0);
    settle_block();
    // Zero debounce finishes on the first debouncing tick; zero long press
    // makes any hold long.
    write_reg(REG_DEBOUNCE_TICKS, 16'd0);
    write_reg(REG_LONG_PRESS, 16'd0);
    // The spare index must not disturb any timing register.
    write_reg(REG_UNUSED, 16'hFFFF);
    press_gesture(2, 3, 0);
    settle_block();
  endtask

  // Full-scale timing: a debounce that cannot complete within the run, then a
  // double-click window so wide that two clicks far apart still pair.
  task automatic test_full_scale_timing();
    idle_on   = 1'b1;
    gap_pct   = 5;
    stall_pct = 5;
    apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_level(1'b1, 30);
    send_level(1'b0, 10);
    apply_timing(16'd1, 16'hFFFF, 16'hFFFF);
    press_gesture(3, 2, 0);
    send_level(1'b0, 60);
    press_gesture(3, 2, 0);
    settle_block();
  endtask

  // Random gestures under several timing settings; the last setting runs
  // with no idling on either side.
  task automatic test_random_gestures();
    int phase;
    int target;
    int deb;
    int lng;
    int dbl;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin deb = 1; lng = 1;  dbl = 1; end
        1: begin deb = 2; lng = 8;  dbl = 5; end
        2: begin deb = 4; lng = 20; dbl = 12; end
        3: begin deb = 3; lng = 5;  dbl = 40; end
        default: begin
          deb = $urandom_range(6, 1);
          lng = $urandom_range(30, 1);
          dbl = $urandom_range(30, 1);
        end
      endcase
      idle_on   = (phase != 5);
      gap_pct   = $urandom_range(30, 5);
      stall_pct = $urandom_range(30, 5);
      apply_timing(deb[CFG_W-1:0], lng[CFG_W-1:0], dbl[CFG_W-1:0]);
      target = n_items + 90;
      while (n_items < target) begin
        if ($urandom_range(99) < 80) begin
          press_gesture($urandom_range(2 * lng + deb + 3, 1),
                        $urandom_range(2 * dbl + deb + 3, 1),
                        $urandom_range(3));
        end else begin
          repeat ($urandom_range(8, 1)) send_tick(1'($urandom_range(1)));
        end
      end
    end
    settle_block();
  endtask

  // Output stall in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (idle_on && !rst && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(19, 1);
    end
    out_stall <= (stall_left != 0);
  end

  // Compares each accepted result with the oldest owed one.
  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("result with no item outstanding: event_res %0d is_pressed %0d",
               event_res, is_pressed);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (event_res !== want.ev) begin
          $error("event_res expected %0d actual %0d", want.ev, event_res);
          errors++;
        end
        if (is_pressed !== want.pressed) begin
          $error("is_pressed expected %0d actual %0d", want.pressed, is_pressed);
          errors++;
        end
        case (want.ev)
          EV_SHORT:  n_short++;
          EV_LONG:   n_long++;
          EV_DOUBLE: n_double++;
          default: ;
        endcase
      end
    end
  end

  // Ends a hung run: no item, result or write for too many cycles.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    reset_classifier_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults_after_reset();
    test_directed_cases();
    test_full_scale_timing();
    test_random_gestures();
    repeat (5) @(posedge clk);
    $display("Covered %0d ticks and %0d register writes, from full-scale timing down to zero.",
             n_items, n_writes);
    $display("Classified %0d short presses, %0d long presses and %0d double clicks.",
             n_short, n_long, n_double);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
